### sv/slts_pkg.sv
`timescale 1ns / 1ps

package slts_pkg;

  localparam int MAX_CHARS   = 32;
  localparam int NUM_UNITS   = 4;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_W     = 6;
  localparam int STRIP_COLS  = (NUM_UNITS + 1) * GLYPH_W;

  localparam int SLOT_W      = $clog2(MAX_CHARS);
  localparam int LEN_W       = SLOT_W + 1;
  localparam int UNIT_W      = $clog2(NUM_UNITS);
  localparam int COL_W       = 3;
  localparam int SHIFT_W     = 3;
  localparam int STRIP_IDX_W = $clog2(STRIP_COLS);
  localparam int PERIOD_W    = 16;
  localparam int MODE_W      = 2;
  localparam int CMD_W       = 2;
  localparam int ROW_W       = 7;
  localparam int SEL_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_PERIOD = 1'd1;

  localparam logic [MODE_W-1:0]   DISPLAY_MODE_RST  = MODE_STATIC;
  localparam logic [PERIOD_W-1:0] SCROLL_PERIOD_RST = 16'd100;
  localparam logic [SEL_W-1:0]    SEL_ALL           = 5'h1F;

  typedef logic [ROW_W-1:0] col_t;
  typedef col_t [GLYPH_COLS-1:0] glyph_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  glyph_col0;
    logic [ROW_W-1:0]  glyph_col1;
    logic [ROW_W-1:0]  glyph_col2;
    logic [ROW_W-1:0]  glyph_col3;
    logic [ROW_W-1:0]  glyph_col4;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_bits;
    logic [SEL_W-1:0]  column_select_n;
    logic [UNIT_W-1:0] unit_latch;
  } out_item_t;

  typedef struct packed {
    logic             tick;
    logic             fill;
    logic             restart;
    logic [LEN_W-1:0] new_len;
  } scroll_ctl_t;

endpackage

### sv/slts_glyph_store.sv
`timescale 1ns / 1ps

module slts_glyph_store (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [slts_pkg::SLOT_W-1:0] wr_slot,
  input  slts_pkg::glyph_t      wr_glyph,
  input  logic [slts_pkg::SLOT_W-1:0] rd_index,
  output slts_pkg::glyph_t      rd_glyph,
  output slts_pkg::glyph_t      head [slts_pkg::NUM_UNITS+1]
);
  import slts_pkg::*;

  glyph_t store [MAX_CHARS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_slot] <= wr_glyph;
    end
  end

  assign rd_glyph = store[rd_index];

  // the fill beat only ever needs the leading glyphs
  for (genvar g = 0; g <= NUM_UNITS; g++) begin : g_head
    assign head[g] = store[g];
  end

endmodule

### sv/slts_window.sv
`timescale 1ns / 1ps

module slts_window (
  input  logic                          clk,
  input  logic                          rst,
  input  slts_pkg::scroll_ctl_t         ctl,
  input  logic [slts_pkg::MODE_W-1:0]   display_mode,
  input  logic [slts_pkg::PERIOD_W-1:0] scroll_period,
  input  slts_pkg::glyph_t              head [slts_pkg::NUM_UNITS+1],
  input  slts_pkg::glyph_t              rd_glyph,
  output logic [slts_pkg::SLOT_W-1:0]   rd_index,
  output slts_pkg::col_t                strip_view [slts_pkg::STRIP_COLS],
  output logic [slts_pkg::SHIFT_W-1:0]  shift_view
);
  import slts_pkg::*;

  col_t                strip [STRIP_COLS];
  col_t                strip_next [STRIP_COLS];
  logic [PERIOD_W-1:0] tick_count, tick_count_next;
  logic [SHIFT_W-1:0]  sub_shift, sub_shift_next;
  logic [LEN_W-1:0]    next_index, next_index_next;
  logic [LEN_W-1:0]    text_length, text_length_next;
  logic                finished, finished_next;

  logic                scroll_on;
  logic [PERIOD_W-1:0] period_eff;
  logic                tick_wrap;
  logic [LEN_W-1:0]    idx_m;
  logic                fin_m;
  logic                take_glyph;
  glyph_t              enter;
  glyph_t              fill_glyph;

  always_comb begin
    scroll_on  = ctl.tick && ((display_mode == MODE_ONCE && !finished) ||
                              display_mode == MODE_LOOP);
    period_eff = (scroll_period == '0) ? PERIOD_W'(1) : scroll_period;
    tick_wrap  = ({1'b0, tick_count} + (PERIOD_W+1)'(1)) >= {1'b0, period_eff};

    // text wraps or ends before the next glyph is fetched
    idx_m = next_index;
    fin_m = finished;
    if (next_index >= text_length) begin
      if (display_mode == MODE_ONCE) begin
        fin_m = 1'b1;
      end
      idx_m = '0;
    end
    take_glyph = !fin_m && (text_length != '0);
    rd_index   = idx_m[SLOT_W-1:0];
    enter      = take_glyph ? rd_glyph : '0;
  end

  always_comb begin
    strip_next       = strip;
    tick_count_next  = tick_count;
    sub_shift_next   = sub_shift;
    next_index_next  = next_index;
    text_length_next = text_length;
    finished_next    = finished;
    fill_glyph       = '0;
    priority if (ctl.restart) begin
      text_length_next = ctl.new_len;
      tick_count_next  = '0;
      sub_shift_next   = '0;
      next_index_next  = '0;
      finished_next    = 1'b0;
    end else if (ctl.fill) begin
      for (int g = 0; g <= NUM_UNITS; g++) begin
        fill_glyph = (LEN_W'(g) < text_length) ? head[g] : '0;
        for (int j = 0; j < GLYPH_COLS; j++) begin
          strip_next[g*GLYPH_W + j] = fill_glyph[j];
        end
        strip_next[g*GLYPH_W + GLYPH_COLS] = '0;
      end
    end else if (scroll_on) begin
      if (tick_wrap) begin
        tick_count_next = '0;
        if (sub_shift >= SHIFT_W'(GLYPH_W - 1)) begin
          sub_shift_next  = '0;
          finished_next   = fin_m;
          next_index_next = take_glyph ? idx_m + LEN_W'(1) : idx_m;
          for (int i = 0; i < NUM_UNITS*GLYPH_W; i++) begin
            strip_next[i] = strip[i + GLYPH_W];
          end
          for (int j = 0; j < GLYPH_COLS; j++) begin
            strip_next[NUM_UNITS*GLYPH_W + j] = enter[j];
          end
          strip_next[STRIP_COLS-1] = '0;
        end else begin
          sub_shift_next = sub_shift + SHIFT_W'(1);
        end
      end else begin
        tick_count_next = tick_count + PERIOD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STRIP_COLS; i++) begin
        strip[i] <= '0;
      end
      tick_count  <= '0;
      sub_shift   <= '0;
      next_index  <= '0;
      text_length <= '0;
      finished    <= 1'b0;
    end else begin
      strip       <= strip_next;
      tick_count  <= tick_count_next;
      sub_shift   <= sub_shift_next;
      next_index  <= next_index_next;
      text_length <= text_length_next;
      finished    <= finished_next;
    end
  end

  // the scan reads the window as it stands after this beat's scroll step
  assign strip_view = strip_next;
  assign shift_view = sub_shift_next;

endmodule

### sv/slts_scan.sv
`timescale 1ns / 1ps

module slts_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  slts_pkg::scroll_ctl_t        ctl,
  input  slts_pkg::col_t               strip_view [slts_pkg::STRIP_COLS],
  input  logic [slts_pkg::SHIFT_W-1:0] shift_view,
  input  logic                         out_ready,
  output logic                         out_valid,
  output slts_pkg::out_item_t          out_data
);
  import slts_pkg::*;

  logic [UNIT_W-1:0]      scan_unit, scan_unit_next;
  logic [COL_W-1:0]       scan_column, scan_column_next;
  logic [STRIP_IDX_W-1:0] pos;
  out_item_t              result;

  always_comb begin
    pos = STRIP_IDX_W'(scan_unit) * STRIP_IDX_W'(GLYPH_W) +
          STRIP_IDX_W'(scan_column) + STRIP_IDX_W'(shift_view);
    result.row_bits        = (int'(pos) < STRIP_COLS) ? strip_view[pos] : '0;
    result.column_select_n = SEL_ALL &
        ~(SEL_W'(1) << (COL_W'(GLYPH_COLS - 1) - scan_column));
    result.unit_latch      = scan_unit;
  end

  // unit steps every tick; the column steps after the last unit
  always_comb begin
    scan_unit_next   = scan_unit;
    scan_column_next = scan_column;
    priority if (ctl.restart) begin
      scan_unit_next   = '0;
      scan_column_next = '0;
    end else if (ctl.tick) begin
      if (scan_unit == UNIT_W'(NUM_UNITS - 1)) begin
        scan_unit_next   = '0;
        scan_column_next = (scan_column == COL_W'(GLYPH_COLS - 1)) ?
                           '0 : scan_column + COL_W'(1);
      end else begin
        scan_unit_next = scan_unit + UNIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_unit   <= '0;
      scan_column <= '0;
      out_valid   <= 1'b0;
    end else begin
      scan_unit   <= scan_unit_next;
      scan_column <= scan_column_next;
      if (ctl.tick) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick) begin
      out_data <= result;
    end
  end

endmodule

### sv/scrolling_led_text_scanner.sv
`timescale 1ns / 1ps
// A tick beat shows its column in the cycle after acceptance.
// Throughput: one beat per cycle; a new beat is taken while the result
// register is empty or being drained in the same cycle.
// Reset (synchronous, active high) clears window, counters and scan position
// and returns the configuration to its defaults (static mode, period 100);
// the glyph store holds no value until written.

module scrolling_led_text_scanner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  slts_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output slts_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [slts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slts_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import slts_pkg::*;

  logic [MODE_W-1:0]   display_mode;
  logic [PERIOD_W-1:0] scroll_period;
  logic                accept;
  logic                wr_en;
  glyph_t              wr_glyph;
  scroll_ctl_t         ctl;
  glyph_t              head [NUM_UNITS+1];
  glyph_t              rd_glyph;
  logic [SLOT_W-1:0]   rd_index;
  col_t                strip_view [STRIP_COLS];
  logic [SHIFT_W-1:0]  shift_view;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode  <= DISPLAY_MODE_RST;
      scroll_period <= SCROLL_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DISPLAY_MODE:  display_mode  <= cfg_data[MODE_W-1:0];
        REG_SCROLL_PERIOD: scroll_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    wr_en       = accept && (in_data.cmd == CMD_WRITE);
    wr_glyph    = {in_data.glyph_col4, in_data.glyph_col3, in_data.glyph_col2,
                   in_data.glyph_col1, in_data.glyph_col0};
    ctl.tick    = accept && (in_data.cmd == CMD_TICK);
    ctl.fill    = accept && (in_data.cmd == CMD_FILL);
    ctl.restart = wr_en && in_data.end_of_text;
    ctl.new_len = LEN_W'(in_data.slot) + LEN_W'(1);
  end

  slts_glyph_store u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_slot  (in_data.slot),
    .wr_glyph (wr_glyph),
    .rd_index (rd_index),
    .rd_glyph (rd_glyph),
    .head     (head)
  );

  slts_window u_window (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .display_mode  (display_mode),
    .scroll_period (scroll_period),
    .head          (head),
    .rd_glyph      (rd_glyph),
    .rd_index      (rd_index),
    .strip_view    (strip_view),
    .shift_view    (shift_view)
  );

  slts_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .strip_view (strip_view),
    .shift_view (shift_view),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_BEATS = 70;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DISPLAY_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scrolling_led_text_scanner dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // stimulus and scoreboard
  in_item_t led_cmds_q[$];
  out_item_t pending_cols[$];
  bit in_took = 1'b0;
  bit calm = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int cyc = 0;
  int mismatches = 0;
  int columns_seen = 0;
  int beats_queued = 0;
  int ignored_queued = 0;
  bit [MAX_CHARS-1:0] slot_written = '0;
  int written_prefix = 0;

  logic [MODE_W-1:0] phase_mode [NUM_PHASES] = '{MODE_ONCE, MODE_LOOP, MODE_STATIC,
    MODE_UNUSED, MODE_ONCE, MODE_LOOP, MODE_ONCE, MODE_LOOP, MODE_ONCE, MODE_STATIC,
    MODE_LOOP, MODE_ONCE};
  logic [PERIOD_W-1:0] phase_period [NUM_PHASES] = '{16'd1, 16'd1, 16'd3, 16'd2,
    16'hFFFF, 16'd2, 16'd0, 16'd1, 16'd4, 16'd1, 16'd7, 16'd1};

  // scanner state as predicted
  glyph_t glyph_mem [MAX_CHARS];
  col_t strip [STRIP_COLS];
  int tick_cnt = 0;
  int shift = 0;
  int next_idx = 0;
  int text_len = 0;
  bit frozen = 1'b0;
  int scan_u = 0;
  int scan_c = 0;
  logic [MODE_W-1:0] disp_mode = DISPLAY_MODE_RST;
  logic [PERIOD_W-1:0] step_period = SCROLL_PERIOD_RST;

  initial begin
    for (int i = 0; i < STRIP_COLS; i++) strip[i] = '0;
  end

  function automatic glyph_t text_glyph(input int idx);
    if (idx < text_len && idx < MAX_CHARS) return glyph_mem[idx];
    return '0;
  endfunction

  function automatic void place_glyph(input int pos, input glyph_t g);
    for (int j = 0; j < GLYPH_COLS; j++) strip[pos * GLYPH_W + j] = g[j];
    strip[pos * GLYPH_W + GLYPH_COLS] = '0;
  endfunction

  function automatic void advance_window();
    glyph_t g;
    g = '0;
    for (int i = 0; i < NUM_UNITS * GLYPH_W; i++) strip[i] = strip[i + GLYPH_W];
    if (next_idx >= text_len) begin
      if (disp_mode == MODE_ONCE) frozen = 1'b1;
      next_idx = 0;
    end
    if (!frozen && text_len != 0) begin
      g = text_glyph(next_idx);
      next_idx++;
    end
    place_glyph(NUM_UNITS, g);
  endfunction

  function automatic void scroll_step();
    int per;
    per = (step_period == 0) ? 1 : int'(step_period);
    if (tick_cnt + 1 >= per) begin
      tick_cnt = 0;
      shift++;
      if (shift >= GLYPH_W) begin
        shift = 0;
        advance_window();
      end
    end else begin
      tick_cnt++;
    end
  endfunction

  // returns 1 when the beat produces a column
  function automatic bit predict_beat(input in_item_t it, output out_item_t col);
    int idx;
    col = '0;
    case (it.cmd)
      CMD_WRITE: begin
        glyph_mem[it.slot] = {it.glyph_col4, it.glyph_col3, it.glyph_col2, it.glyph_col1,
                              it.glyph_col0};
        if (it.end_of_text) begin
          text_len = int'(it.slot) + 1;
          tick_cnt = 0;
          shift = 0;
          next_idx = 0;
          frozen = 1'b0;
          scan_u = 0;
          scan_c = 0;
        end
        return 1'b0;
      end
      CMD_FILL: begin
        for (int g = 0; g <= NUM_UNITS; g++) place_glyph(g, text_glyph(g));
        return 1'b0;
      end
      CMD_TICK: begin
        if ((disp_mode == MODE_ONCE && !frozen) || disp_mode == MODE_LOOP) scroll_step();
        idx = scan_u * GLYPH_W + scan_c + shift;
        col.row_bits = (idx < STRIP_COLS) ? strip[idx] : '0;
        col.column_select_n = SEL_ALL & ~(5'b1 << (4 - scan_c));
        col.unit_latch = scan_u[UNIT_W-1:0];
        scan_u++;
        if (scan_u >= NUM_UNITS) begin
          scan_u = 0;
          scan_c++;
          if (scan_c >= GLYPH_COLS) scan_c = 0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void cmp_field(input string fld, input logic [6:0] want,
                                    input logic [6:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, fld, want, got);
    end
  endfunction

  // sender and receiver handshakes, driven on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (led_cmds_q.size() > 0) begin
          in_data <= led_cmds_q.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 14);
      end
    end
  end

  // monitor: check columns against the oldest prediction, predict accepted beats
  always @(posedge clk) begin
    out_item_t want;
    out_item_t col;
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("scrolling_led_text_scanner test failed");
      $finish;
    end else begin
      in_took = in_valid && in_ready;
      if (!rst && out_valid && out_ready) begin
        if (pending_cols.size() == 0) begin
          mismatches++;
          $display("%0t: column %0h arrived with none expected", $time, out_data);
        end else begin
          want = pending_cols.pop_front();
          cmp_field("row_bits", want.row_bits, out_data.row_bits);
          cmp_field("column_select_n", 7'(want.column_select_n),
                    7'(out_data.column_select_n));
          cmp_field("unit_latch", 7'(want.unit_latch), 7'(out_data.unit_latch));
          columns_seen++;
        end
      end
      if (!rst && in_took) begin
        if (predict_beat(in_data, col)) pending_cols.push_back(col);
      end
    end
  end

  function automatic in_item_t random_beat(input logic [CMD_W-1:0] op);
    logic [63:0] r;
    in_item_t it;
    r = {$urandom(), $urandom()};
    it = r[$bits(in_item_t)-1:0];
    it.cmd = op;
    return it;
  endfunction

  // an end marker is only let through once every lower slot holds a glyph
  function automatic void queue_beat(input in_item_t it);
    if (it.cmd == CMD_WRITE) begin
      if (it.end_of_text && int'(it.slot) > written_prefix) it.end_of_text = 1'b0;
      slot_written[it.slot] = 1'b1;
      while (written_prefix < MAX_CHARS && slot_written[written_prefix]) written_prefix++;
    end
    if (it.cmd == CMD_UNUSED) ignored_queued++;
    else beats_queued++;
    led_cmds_q.push_back(it);
  endfunction

  function automatic void write_glyph(input int slot, input bit last);
    in_item_t it;
    it = random_beat(CMD_WRITE);
    it.slot = slot[SLOT_W-1:0];
    it.end_of_text = last;
    queue_beat(it);
  endfunction

  function automatic void send_text(input int len);
    for (int s = 0; s < len; s++) write_glyph(s, s == len - 1);
  endfunction

  function automatic void send_ticks(input int n);
    repeat (n) queue_beat(random_beat(CMD_TICK));
  endfunction

  task automatic build_phase(input int target);
    int stop;
    int pick;
    int len;
    stop = beats_queued + target;
    while (beats_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, MAX_CHARS) : $urandom_range(1, 6);
        send_text(len);
        if ($urandom_range(0, 3) != 0) queue_beat(random_beat(CMD_FILL));
        send_ticks($urandom_range(10, 70));
      end else if (pick < 62) begin
        send_ticks($urandom_range(1, 40));
      end else if (pick < 72) begin
        queue_beat(random_beat(CMD_FILL));
      end else if (pick < 84) begin
        queue_beat(random_beat(CMD_WRITE));
      end else if (pick < 92) begin
        // broken text: glyphs with no end marker, then carry on scanning
        repeat ($urandom_range(1, 4)) write_glyph($urandom_range(0, MAX_CHARS - 1), 1'b0);
        send_ticks($urandom_range(5, 20));
      end else begin
        queue_beat(random_beat(CMD_UNUSED));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DISPLAY_MODE) disp_mode = val[MODE_W-1:0];
    else step_period = val;
  endtask

  // sender holds off until every column owed has been seen
  task automatic wait_idle();
    while (led_cmds_q.size() != 0 || in_valid || pending_cols.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    phase_period[10] = PERIOD_W'($urandom_range(5, 12));
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: period zero, empty text scrolling, fills past the text, extremes
    write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(MODE_LOOP));
    write_reg(REG_SCROLL_PERIOD, '0);
    send_ticks(7);
    queue_beat(random_beat(CMD_FILL));
    queue_beat(random_beat(CMD_UNUSED));
    it = random_beat(CMD_WRITE);
    it.slot = '0;
    it.end_of_text = 1'b0;
    it.glyph_col0 = 7'h7F; it.glyph_col1 = 7'h7F; it.glyph_col2 = 7'h7F;
    it.glyph_col3 = 7'h7F; it.glyph_col4 = 7'h7F;
    queue_beat(it);
    it.slot = 5'd1;
    it.end_of_text = 1'b1;
    it.glyph_col0 = '0; it.glyph_col1 = '0; it.glyph_col2 = '0;
    it.glyph_col3 = '0; it.glyph_col4 = '0;
    queue_beat(it);
    queue_beat(random_beat(CMD_FILL));
    write_glyph(MAX_CHARS - 1, 1'b0);
    send_ticks(12);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(phase_mode[ph]));
      write_reg(REG_SCROLL_PERIOD, phase_period[ph]);
      if (ph == 2) begin
        send_text(MAX_CHARS);
        queue_beat(random_beat(CMD_FILL));
        send_ticks(60);
      end
      build_phase(PHASE_BEATS);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (pending_cols.size() != 0) begin
      mismatches++;
      $display("%0t: %0d columns never arrived", $time, pending_cols.size());
    end
    $display("Sent %0d command beats and %0d ignored ones across %0d display settings;",
             beats_queued, ignored_queued, NUM_PHASES + 1);
    $display("checked %0d scanned columns, %0d mismatches.", columns_seen, mismatches);
    if (mismatches == 0) begin
      $display("scrolling_led_text_scanner test passed");
    end else begin
      $display("scrolling_led_text_scanner test failed");
    end
    $finish;
  end

endmodule
